// File: src/rcpc_pkg.sv
// Shared types, codes and constants of the reel click position controller.
`default_nettype none
package rcpc_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int CMP_W      = (DEPTH_BITS > 16 ? DEPTH_BITS : 16) + 1;
  localparam int CFG_AW     = 5;

  localparam logic signed [DEPTH_BITS-1:0] DEPTH_HI = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_LO = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
  localparam logic signed [15:0] PULLUP_TARGET = -16'sd10;

  localparam logic [2:0] REG_NEUTRAL_DUTY  = 3'd0;
  localparam logic [2:0] REG_DOWN_DUTY     = 3'd1;
  localparam logic [2:0] REG_UP_DUTY       = 3'd2;
  localparam logic [2:0] REG_MAX_DEPTH     = 3'd3;
  localparam logic [2:0] REG_MIN_DEPTH     = 3'd4;
  localparam logic [2:0] REG_HOME_WINDOW   = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_INNER = 3'd6;
  localparam logic [2:0] REG_TIMEOUT_OUTER = 3'd7;

  typedef enum logic [1:0] {
    OP_CLICK   = 2'd0,
    OP_LIMIT   = 2'd1,
    OP_PULL    = 2'd2,
    OP_CONTROL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_HOMED  = 2'd1,
    EV_LIMIT  = 2'd2,
    EV_BOUNDS = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    SC_DONE    = 3'd0,
    SC_DOWN    = 3'd1,
    SC_UP      = 3'd2,
    SC_TIMEOUT = 3'd3,
    SC_LIMIT   = 3'd4
  } step_code_t;

  typedef struct packed {
    logic [15:0]        neutral_duty;
    logic [15:0]        down_duty;
    logic [15:0]        up_duty;
    logic [14:0]        max_depth;
    logic signed [15:0] min_depth;
    logic [14:0]        home_window;
    logic [15:0]        timeout_inner;
    logic [15:0]        timeout_outer;
  } cfg_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] target_depth;
    logic               limit_open;
    logic [15:0]        pulse_width;
  } item_t;

  typedef struct packed {
    step_code_t         step_code;
    logic [15:0]        motor_duty;
    logic [15:0]        actuator_duty;
    dir_t               reel_direction;
    event_t             event_code;
    logic               stopped;
    logic signed [15:0] depth_now;
    logic signed [15:0] saved_target;
    logic               reel_active;
  } result_t;

endpackage
`default_nettype wire

// File: src/rcpc_if.sv
// Input and result stream interfaces of the reel click position controller.
`default_nettype none
interface rcpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] target_depth;
  logic               limit_open;
  logic [15:0]        pulse_width;

  modport source (output valid, opcode, target_depth, limit_open, pulse_width, input ready);
  modport sink   (input valid, opcode, target_depth, limit_open, pulse_width, output ready);
endinterface

interface rcpc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         step_code;
  logic [15:0]        motor_duty;
  logic [15:0]        actuator_duty;
  logic [1:0]         reel_direction;
  logic [1:0]         event_code;
  logic               stopped;
  logic signed [15:0] depth_now;
  logic signed [15:0] saved_target;
  logic               reel_active;

  modport source (output valid, step_code, motor_duty, actuator_duty, reel_direction,
                  event_code, stopped, depth_now, saved_target, reel_active,
                  input ready);
  modport sink   (input valid, step_code, motor_duty, actuator_duty, reel_direction,
                  event_code, stopped, depth_now, saved_target, reel_active,
                  output ready);
endinterface
`default_nettype wire

// File: src/rcpc_cfg.sv
// APB-style configuration register file.
`default_nettype none
module rcpc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [rcpc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready,
  output rcpc_pkg::cfg_t                     cfg
);

  rcpc_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx        = cfg_paddr[rcpc_pkg::CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_duty  <= 16'd3000;
      cfg_r.down_duty     <= 16'd2000;
      cfg_r.up_duty       <= 16'd4000;
      cfg_r.max_depth     <= 15'd1000;
      cfg_r.min_depth     <= 16'sd0;
      cfg_r.home_window   <= 15'd10;
      cfg_r.timeout_inner <= 16'd1000;
      cfg_r.timeout_outer <= 16'd100;
    end else if (wr_en) begin
      case (idx)
        rcpc_pkg::REG_NEUTRAL_DUTY:  cfg_r.neutral_duty  <= cfg_pwdata[15:0];
        rcpc_pkg::REG_DOWN_DUTY:     cfg_r.down_duty     <= cfg_pwdata[15:0];
        rcpc_pkg::REG_UP_DUTY:       cfg_r.up_duty       <= cfg_pwdata[15:0];
        rcpc_pkg::REG_MAX_DEPTH:     cfg_r.max_depth     <= cfg_pwdata[14:0];
        rcpc_pkg::REG_MIN_DEPTH:     cfg_r.min_depth     <= cfg_pwdata[15:0];
        rcpc_pkg::REG_HOME_WINDOW:   cfg_r.home_window   <= cfg_pwdata[14:0];
        rcpc_pkg::REG_TIMEOUT_INNER: cfg_r.timeout_inner <= cfg_pwdata[15:0];
        rcpc_pkg::REG_TIMEOUT_OUTER: cfg_r.timeout_outer <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rcpc_pkg::REG_NEUTRAL_DUTY:  cfg_prdata = 32'(cfg_r.neutral_duty);
      rcpc_pkg::REG_DOWN_DUTY:     cfg_prdata = 32'(cfg_r.down_duty);
      rcpc_pkg::REG_UP_DUTY:       cfg_prdata = 32'(cfg_r.up_duty);
      rcpc_pkg::REG_MAX_DEPTH:     cfg_prdata = 32'(cfg_r.max_depth);
      rcpc_pkg::REG_MIN_DEPTH:     cfg_prdata = 32'(unsigned'(cfg_r.min_depth));
      rcpc_pkg::REG_HOME_WINDOW:   cfg_prdata = 32'(cfg_r.home_window);
      rcpc_pkg::REG_TIMEOUT_INNER: cfg_prdata = 32'(cfg_r.timeout_inner);
      rcpc_pkg::REG_TIMEOUT_OUTER: cfg_prdata = 32'(cfg_r.timeout_outer);
      default:                     cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/rcpc_core.sv
// Controller state and the single-pass event update logic.
`default_nettype none
module rcpc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire rcpc_pkg::item_t  item,
  input  wire rcpc_pkg::cfg_t   cfg,
  output rcpc_pkg::result_t     res
);

  localparam int DW = rcpc_pkg::DEPTH_BITS;
  localparam int CW = rcpc_pkg::CMP_W;

  logic signed [DW-1:0] depth_r, depth_nxt, depth_clk;
  rcpc_pkg::dir_t       dir_r, dir_nxt;
  rcpc_pkg::event_t     fault_r, fault_nxt;
  logic                 run_r, run_nxt;
  logic                 pull_r, pull_nxt;
  logic                 stop_r, stop_nxt;
  logic signed [15:0]   set_r, set_nxt;
  logic [15:0]          inner_r, inner_nxt, inner_inc;
  logic [15:0]          outer_r, outer_nxt;
  logic [15:0]          motor_r, motor_nxt;
  logic [15:0]          act_r, act_nxt;
  rcpc_pkg::step_code_t code;

  logic signed [CW-1:0] clk_x, cur_x, max_x, min_x, home_x, tgt_x;

  always_comb begin
    depth_clk = depth_r;
    if (run_r && dir_r == rcpc_pkg::DIR_UP && depth_r < rcpc_pkg::DEPTH_HI) begin
      depth_clk = depth_r + rcpc_pkg::DEPTH_ONE;
    end
    if (run_r && dir_r == rcpc_pkg::DIR_DOWN && depth_r > rcpc_pkg::DEPTH_LO) begin
      depth_clk = depth_r - rcpc_pkg::DEPTH_ONE;
    end
    clk_x     = CW'($signed(depth_clk));
    cur_x     = CW'($signed(depth_r));
    max_x     = CW'(cfg.max_depth);
    home_x    = CW'(cfg.home_window);
    min_x     = CW'($signed(cfg.min_depth));
    tgt_x     = CW'($signed(item.target_depth));
    inner_inc = inner_r + 16'd1;
  end

  always_comb begin
    depth_nxt = depth_r;
    dir_nxt   = dir_r;
    fault_nxt = fault_r;
    run_nxt   = run_r;
    pull_nxt  = pull_r;
    stop_nxt  = stop_r;
    set_nxt   = set_r;
    inner_nxt = inner_r;
    outer_nxt = outer_r;
    motor_nxt = motor_r;
    act_nxt   = act_r;
    code      = rcpc_pkg::SC_DONE;
    case (item.opcode)
      rcpc_pkg::OP_CLICK: begin
        depth_nxt = depth_clk;
        if (clk_x > max_x) begin
          stop_nxt  = 1'b1;
          run_nxt   = 1'b0;
          fault_nxt = rcpc_pkg::EV_BOUNDS;
        end
        if (clk_x < min_x) begin
          depth_nxt = '0;
        end
        inner_nxt = '0;
        outer_nxt = '0;
      end
      rcpc_pkg::OP_LIMIT: begin
        run_nxt = 1'b0;
        if (dir_r != rcpc_pkg::DIR_IDLE && run_r && cur_x < home_x) begin
          depth_nxt = '0;
          dir_nxt   = rcpc_pkg::DIR_IDLE;
          fault_nxt = pull_r ? rcpc_pkg::EV_NONE : rcpc_pkg::EV_HOMED;
        end else begin
          fault_nxt = rcpc_pkg::EV_LIMIT;
        end
        stop_nxt = 1'b1;
      end
      rcpc_pkg::OP_PULL: begin
        if (item.pulse_width < cfg.neutral_duty) begin
          set_nxt   = rcpc_pkg::PULLUP_TARGET;
          run_nxt   = 1'b1;
          dir_nxt   = rcpc_pkg::DIR_DOWN;
          stop_nxt  = 1'b0;
          pull_nxt  = 1'b1;
          inner_nxt = '0;
          outer_nxt = '0;
        end else if (pull_r) begin
          run_nxt   = 1'b0;
          fault_nxt = rcpc_pkg::EV_NONE;
          set_nxt   = 16'(depth_r);
          stop_nxt  = 1'b1;
          pull_nxt  = 1'b0;
        end
      end
      rcpc_pkg::OP_CONTROL: begin
        // two-level timeout: inner wraps into outer
        inner_nxt = inner_inc;
        if (inner_inc > cfg.timeout_inner) begin
          inner_nxt = '0;
          outer_nxt = outer_r + 16'd1;
        end
        if (outer_nxt > cfg.timeout_outer) begin
          stop_nxt = 1'b1;
          code     = rcpc_pkg::SC_TIMEOUT;
        end else if (cur_x != tgt_x && item.limit_open) begin
          if (cur_x > tgt_x) begin
            dir_nxt   = rcpc_pkg::DIR_DOWN;
            motor_nxt = cfg.down_duty;
            code      = rcpc_pkg::SC_DOWN;
          end else begin
            dir_nxt   = rcpc_pkg::DIR_UP;
            motor_nxt = cfg.up_duty;
            code      = rcpc_pkg::SC_UP;
          end
        end else begin
          dir_nxt   = rcpc_pkg::DIR_IDLE;
          run_nxt   = 1'b0;
          act_nxt   = cfg.neutral_duty;
          motor_nxt = cfg.neutral_duty;
          stop_nxt  = 1'b1;
          if (item.limit_open) begin
            code = rcpc_pkg::SC_DONE;
          end else begin
            fault_nxt = rcpc_pkg::EV_LIMIT;
            code      = rcpc_pkg::SC_LIMIT;
          end
        end
      end
      default: ;
    endcase

    res.step_code      = code;
    res.motor_duty     = motor_nxt;
    res.actuator_duty  = act_nxt;
    res.reel_direction = dir_nxt;
    res.event_code     = fault_nxt;
    res.stopped        = stop_nxt;
    res.depth_now      = 16'(depth_nxt);
    res.saved_target   = set_nxt;
    res.reel_active    = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      dir_r   <= rcpc_pkg::DIR_IDLE;
      fault_r <= rcpc_pkg::EV_NONE;
      run_r   <= 1'b0;
      pull_r  <= 1'b0;
      stop_r  <= 1'b1;
      set_r   <= '0;
      inner_r <= '0;
      outer_r <= '0;
      motor_r <= '0;
      act_r   <= '0;
    end else if (step) begin
      depth_r <= depth_nxt;
      dir_r   <= dir_nxt;
      fault_r <= fault_nxt;
      run_r   <= run_nxt;
      pull_r  <= pull_nxt;
      stop_r  <= stop_nxt;
      set_r   <= set_nxt;
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
      motor_r <= motor_nxt;
      act_r   <= act_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/reel_click_position_controller.sv
// Top level of the reel click position controller: stream registers and instances.
`default_nettype none
// Event-driven winch reel position controller. Each input beat carries one
// event chosen by opcode (click pulse, limit-switch edge, pull command width,
// control step) and produces exactly one result beat holding the control step
// code and a snapshot of the controller state after the event. Throughput is
// one beat per clock while the result side does not stall. A result is
// offered once its input beat has passed the input register, which captures
// the beat, and then the result register, which captures the single pass of
// compare/update logic. The input side keeps accepting while a result
// waits, as long as the result register is free or drained in the same
// cycle. Configuration registers sit on an
// APB-style port (byte addresses 0x00..0x1C, pready always high) and are to
// be written only while no beat is in flight. There is no clearing pass:
// the block is ready out of reset.
module reel_click_position_controller (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rcpc_in_if.sink                           in_if,
  rcpc_out_if.source                        out_if,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [rcpc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic      [31:0]                  cfg_prdata,
  output logic                              cfg_pready
);

  rcpc_pkg::cfg_t    cfg;
  rcpc_pkg::item_t   item_r;
  rcpc_pkg::result_t res, res_r;
  logic              in_v_r;
  logic              out_v_r;
  logic              advance;   // input register moves into the result register
  logic              in_take;

  // Input stage advances when the result slot is empty or being drained.
  assign advance     = in_v_r & (~out_v_r | out_if.ready);
  assign in_if.ready = ~in_v_r | advance;
  assign in_take     = in_if.valid & in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode       <= rcpc_pkg::opcode_t'(in_if.opcode);
      item_r.target_depth <= in_if.target_depth;
      item_r.limit_open   <= in_if.limit_open;
      item_r.pulse_width  <= in_if.pulse_width;
    end
  end

  rcpc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // State commits on the same edge the result beat is captured.
  rcpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.step_code      = res_r.step_code;
  assign out_if.motor_duty     = res_r.motor_duty;
  assign out_if.actuator_duty  = res_r.actuator_duty;
  assign out_if.reel_direction = res_r.reel_direction;
  assign out_if.event_code     = res_r.event_code;
  assign out_if.stopped        = res_r.stopped;
  assign out_if.depth_now      = res_r.depth_now;
  assign out_if.saved_target   = res_r.saved_target;
  assign out_if.reel_active    = res_r.reel_active;

endmodule
`default_nettype wire
